// ===== hw/rtl/tga_image_stream_decoder_top_macros.svh =====
// Assertion macros used by the decoder's command queue.
`ifndef TGA_IMAGE_STREAM_DECODER_TOP_MACROS_SVH
`define TGA_IMAGE_STREAM_DECODER_TOP_MACROS_SVH

// Flag a condition that must never hold.
`define TISD_ASSERT_NEVER(lbl, clk, rst_n, bad, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) else $error(msg);

// Flag a consequence that must hold in the cycle after its trigger.
`define TISD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tisd_pkg.sv =====
// Types and constants shared by the TGA stream decoder modules.
`timescale 1ns / 1ps

package tisd_pkg;

    localparam int PIXEL_COUNT_WIDTH = 32;

    localparam logic [1:0] KIND_PIXEL      = 2'd0;
    localparam logic [1:0] KIND_HEADER_OK  = 2'd1;
    localparam logic [1:0] KIND_BAD_SIZE   = 2'd2;
    localparam logic [1:0] KIND_BAD_DEPTH  = 2'd3;

    localparam logic [4:0] POS_TYPE      = 5'd2;
    localparam logic [4:0] POS_WIDTH_LO  = 5'd12;
    localparam logic [4:0] POS_WIDTH_HI  = 5'd13;
    localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
    localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
    localparam logic [4:0] POS_DEPTH     = 5'd16;
    localparam logic [4:0] POS_DESC      = 5'd17;

    localparam logic [7:0] TYPE_RLE_MAPPED = 8'd9;
    localparam logic [7:0] TYPE_RLE_TRUE   = 8'd10;
    localparam logic [7:0] DEPTH_24        = 8'd24;
    localparam logic [7:0] DEPTH_32        = 8'd32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_input;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic        has_alpha;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last_run;
    } t_result;

    // Pixel: payload is the B,G,R,A word. Header: payload is {height, width}.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] payload;
        logic [7:0]  repeat_count;
        logic        has_alpha;
        logic        last_run;
    } t_cmd;

endpackage

// ===== hw/rtl/tisd_front.sv =====
// Byte parser: header checks, packet tracking and pixel assembly.
`timescale 1ns / 1ps

module tisd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tisd_pkg::t_input i_data,
    output logic            o_cmd_valid,
    output tisd_pkg::t_cmd  o_cmd
);
    import tisd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PACKET,
        PH_DATA,
        PH_IDLE
    } t_phase;

    localparam int PCW = PIXEL_COUNT_WIDTH;

    t_phase           r_phase, n_phase, e_phase;
    logic [4:0]       r_pos, n_pos, e_pos;
    logic             r_rle, n_rle, e_rle;
    logic [15:0]      r_w, n_w, e_w;
    logic [15:0]      r_h, n_h, e_h;
    logic             r_four, n_four, e_four;
    logic [PCW-1:0]   r_prem, n_prem, e_prem;
    logic             r_run, n_run, e_run;
    logic [7:0]       r_ppl, n_ppl, e_ppl;
    logic [1:0]       r_bip, n_bip, e_bip;
    logic [31:0]      r_cbuf, n_cbuf, e_cbuf;
    logic [31:0]      r_product, n_product;

    logic [7:0]       b;
    logic             fs;
    logic             bad_size;
    logic [31:0]      cbuf_new;
    logic             last_byte;
    logic [7:0]       rep;
    logic [PCW-1:0]   rep_w;
    logic [PCW-1:0]   rem_left;

    assign b  = i_data.data_byte;
    assign fs = i_data.file_start;

    always_comb begin
        e_phase = fs ? PH_HEADER : r_phase;
        e_pos   = fs ? 5'd0 : r_pos;
        e_rle   = fs ? 1'b0 : r_rle;
        e_w     = fs ? 16'd0 : r_w;
        e_h     = fs ? 16'd0 : r_h;
        e_four  = fs ? 1'b0 : r_four;
        e_prem  = fs ? '0 : r_prem;
        e_run   = fs ? 1'b0 : r_run;
        e_ppl   = fs ? 8'd0 : r_ppl;
        e_bip   = fs ? 2'd0 : r_bip;
        e_cbuf  = fs ? 32'd0 : r_cbuf;
    end

    always_comb begin
        bad_size  = (r_product == 32'd0) || ((r_product >> PCW) != 32'd0);
        cbuf_new  = ((e_bip == 2'd0) ? 32'd0 : e_cbuf) | ({24'd0, b} << {e_bip, 3'b000});
        last_byte = e_four ? (e_bip == 2'd3) : (e_bip == 2'd2);
        rep = 8'd1;
        if (e_rle && e_run) begin
            rep = (e_prem < {{(PCW-8){1'b0}}, e_ppl}) ? e_prem[7:0] : e_ppl;
        end
        if (rep == 8'd0) begin
            rep = 8'd1;
        end
        rep_w    = {{(PCW-8){1'b0}}, rep};
        rem_left = (rep_w >= e_prem) ? '0 : e_prem - rep_w;
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_rle     = r_rle;
        n_w       = r_w;
        n_h       = r_h;
        n_four    = r_four;
        n_prem    = r_prem;
        n_run     = r_run;
        n_ppl     = r_ppl;
        n_bip     = r_bip;
        n_cbuf    = r_cbuf;
        n_product = r_product;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        if (i_valid) begin
            n_phase = e_phase;
            n_pos   = e_pos;
            n_rle   = e_rle;
            n_w     = e_w;
            n_h     = e_h;
            n_four  = e_four;
            n_prem  = e_prem;
            n_run   = e_run;
            n_ppl   = e_ppl;
            n_bip   = e_bip;
            n_cbuf  = e_cbuf;
            case (e_phase)
                PH_HEADER: begin
                    if (e_pos < POS_WIDTH_LO) begin
                        if (e_pos == POS_TYPE) begin
                            n_rle = (b == TYPE_RLE_MAPPED) || (b == TYPE_RLE_TRUE);
                        end
                        n_pos = e_pos + 5'd1;
                    end else if (e_pos == POS_WIDTH_LO) begin
                        n_w[7:0] = b;
                        n_pos    = e_pos + 5'd1;
                    end else if (e_pos == POS_WIDTH_HI) begin
                        n_w[15:8] = b;
                        n_pos     = e_pos + 5'd1;
                    end else if (e_pos == POS_HEIGHT_LO) begin
                        n_h[7:0] = b;
                        n_pos    = e_pos + 5'd1;
                    end else if (e_pos == POS_HEIGHT_HI) begin
                        n_h[15:8] = b;
                        n_product = {16'd0, e_w} * {16'd0, b, e_h[7:0]};
                        n_pos     = e_pos + 5'd1;
                    end else if (e_pos == POS_DEPTH) begin
                        n_four            = (b == DEPTH_32);
                        o_cmd_valid       = 1'b1;
                        o_cmd.payload     = {e_h, e_w};
                        o_cmd.has_alpha   = (b == DEPTH_32);
                        if (bad_size) begin
                            o_cmd.kind = KIND_BAD_SIZE;
                        end else if ((b != DEPTH_24) && (b != DEPTH_32)) begin
                            o_cmd.kind = KIND_BAD_DEPTH;
                        end else begin
                            o_cmd.kind = KIND_HEADER_OK;
                        end
                        if (o_cmd.kind == KIND_HEADER_OK) begin
                            n_prem = r_product[PCW-1:0];
                            n_pos  = POS_DESC;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_phase = e_rle ? PH_PACKET : PH_DATA;
                        n_run   = 1'b0;
                        n_ppl   = 8'd0;
                        n_bip   = 2'd0;
                        n_cbuf  = 32'd0;
                    end
                end
                PH_PACKET: begin
                    n_run   = b[7];
                    n_ppl   = {1'b0, b[6:0]} + 8'd1;
                    n_bip   = 2'd0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_cbuf = cbuf_new;
                    n_bip  = e_bip + 2'd1;
                    if (last_byte) begin
                        n_bip                = 2'd0;
                        n_prem               = rem_left;
                        o_cmd_valid          = 1'b1;
                        o_cmd.kind           = KIND_PIXEL;
                        o_cmd.payload        = cbuf_new;
                        o_cmd.repeat_count   = rep;
                        o_cmd.has_alpha      = e_four;
                        o_cmd.last_run       = (rem_left == '0);
                        if (e_rle) begin
                            n_ppl = (e_run || (e_ppl <= 8'd1)) ? 8'd0 : e_ppl - 8'd1;
                            if (n_ppl == 8'd0) begin
                                n_phase = PH_PACKET;
                            end
                        end
                        if (rem_left == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = e_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= 5'd0;
            r_rle   <= 1'b0;
            r_w     <= 16'd0;
            r_h     <= 16'd0;
            r_four  <= 1'b0;
            r_prem  <= '0;
            r_run   <= 1'b0;
            r_ppl   <= 8'd0;
            r_bip   <= 2'd0;
            r_cbuf  <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rle   <= n_rle;
            r_w     <= n_w;
            r_h     <= n_h;
            r_four  <= n_four;
            r_prem  <= n_prem;
            r_run   <= n_run;
            r_ppl   <= n_ppl;
            r_bip   <= n_bip;
            r_cbuf  <= n_cbuf;
        end
        r_product <= n_product;
    end

endmodule

// ===== hw/rtl/tisd_queue.sv =====
// Command queue between the byte parser and the result stage.
`timescale 1ns / 1ps
`include "tga_image_stream_decoder_top_macros.svh"

module tisd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  tisd_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output tisd_pkg::t_cmd o_rdata,
    output logic           o_empty
);
    import tisd_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `TISD_ASSERT_NEVER(a_no_read_empty, i_clk, i_rst_n, i_rd && o_empty, "read from empty queue")
    `TISD_ASSERT_NEVER(a_no_write_full, i_clk, i_rst_n, i_wr && o_full && !i_rd, "write to full queue")
    `TISD_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_wr && !i_rd, r_count == $past(r_count) + 1'b1, "count did not rise")
    `TISD_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, i_rd && !i_wr, r_count == $past(r_count) - 1'b1, "count did not fall")

endmodule

// ===== hw/rtl/tisd_back.sv =====
// Result stage: format commands into result items and hold the output register.
`timescale 1ns / 1ps

module tisd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  tisd_pkg::t_cmd    i_cmd,
    output logic              o_cmd_rd,
    output tisd_pkg::t_result o_result,
    output logic              o_empty,
    input  logic              i_pop
);
    import tisd_pkg::*;

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    assign o_cmd_rd = i_cmd_valid && (!r_valid || i_pop);
    assign o_empty  = !r_valid;
    assign o_result = r_result;

    always_comb begin
        n_result           = '0;
        n_result.kind      = i_cmd.kind;
        n_result.has_alpha = i_cmd.has_alpha;
        if (i_cmd.kind == KIND_PIXEL) begin
            n_result.red          = i_cmd.payload[23:16];
            n_result.green        = i_cmd.payload[15:8];
            n_result.blue         = i_cmd.payload[7:0];
            n_result.alpha        = i_cmd.has_alpha ? i_cmd.payload[31:24] : 8'd0;
            n_result.repeat_count = i_cmd.repeat_count;
            n_result.last_run     = i_cmd.last_run;
        end else begin
            n_result.image_width  = i_cmd.payload[15:0];
            n_result.image_height = i_cmd.payload[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
        if (o_cmd_rd) begin
            r_result <= n_result;
        end
    end

endmodule

// ===== hw/rtl/tga_image_stream_decoder_top.sv =====
// Top level of the TGA true-colour stream decoder.
// Takes one file byte per cycle while full is low; the parser has a fixed amount of
// work per byte, so a byte may be pushed on every cycle. Each header (on its depth byte)
// and each completed pixel or run gives one result, which passes through a 4-entry
// command queue and a one-entry output register before it can be popped. full rises
// only when the queue holds four results and the output register is held.
`timescale 1ns / 1ps

module tga_image_stream_decoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  tisd_pkg::t_input  i_data,
    output logic              empty,
    input  logic              pop,
    output tisd_pkg::t_result o_result
);
    import tisd_pkg::*;

    logic accept;
    logic cmd_valid;
    t_cmd cmd;
    logic q_empty;
    logic q_rd;
    t_cmd q_data;

    assign accept = push && !full;

    tisd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    tisd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_wdata (cmd),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_rdata (q_data),
        .o_empty (q_empty)
    );

    tisd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_data),
        .o_cmd_rd    (q_rd),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
